// File: hw/rtl/word_paragraph_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WORD_PARAGRAPH_TOKENIZER_CORE_DEFINES_SVH
`define WORD_PARAGRAPH_TOKENIZER_CORE_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define WPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define WPT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/wpt_pkg.sv
package wpt_pkg;

	// Longest text the block is sized for; the field widths cap it at 65536.
	localparam int MaxTextChars = 65536;
	localparam int PosLimitInt  = (MaxTextChars < 65536) ? MaxTextChars : 65536;

	localparam logic [16:0] PosLimit   = 17'(PosLimitInt);
	localparam logic [15:0] CountLimit = 16'(PosLimitInt / 2);

	localparam logic [15:0] CharTab     = 16'd9;
	localparam logic [15:0] CharNewline = 16'd10;
	localparam logic [15:0] CharSpace   = 16'd32;

	localparam logic RecWord   = 1'b0;
	localparam logic RecTotals = 1'b1;

	localparam int RecFifoDepth = 4;
	localparam int RecPtrW      = $clog2(RecFifoDepth);
	localparam int RecCntW      = $clog2(RecFifoDepth + 1);

	typedef enum logic [3:0] {
		PH_PAR_BEGIN  = 4'b0001,
		PH_LINE_BEGIN = 4'b0010,
		PH_IN_WORD    = 4'b0100,
		PH_BETWEEN    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] char_code;
		logic        end_of_text;
	} chr_item_t;

	typedef struct packed {
		logic        record_kind;
		logic [15:0] paragraph_index;
		logic [15:0] word_index;
		logic [15:0] begin_pos;
		logic [16:0] end_pos;
		logic [15:0] total_words;
		logic [15:0] total_paragraphs;
		logic        last_of_run;
	} rec_item_t;

	// Results of one character step: how many records, and the records in order.
	typedef struct packed {
		logic [1:0] count;
		rec_item_t  rec_a;
		rec_item_t  rec_b;
	} step_res_t;

	function automatic logic [15:0] sat_inc(logic [15:0] v);
		return (v < CountLimit) ? v + 16'd1 : v;
	endfunction

endpackage

// File: hw/rtl/wpt_step.sv
`include "word_paragraph_tokenizer_core_defines.svh"

module wpt_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  wpt_pkg::chr_item_t    item,
	output wpt_pkg::step_res_t    res
);

	wpt_pkg::phase_t phase_q, phase_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] par_q, par_d;
	logic [15:0] wip_q, wip_d;
	logic [15:0] begin_q, begin_d;
	logic [15:0] total_q, total_d;
	logic [15:0] wip_base;
	wpt_pkg::rec_item_t word_rec;
	wpt_pkg::rec_item_t tot_rec;

	always_comb begin
		word_rec                  = '0;
		word_rec.record_kind      = wpt_pkg::RecWord;
		word_rec.paragraph_index  = par_q;
		word_rec.word_index       = wip_q;
		word_rec.begin_pos        = begin_q;
		word_rec.end_pos          = pos_q;
		word_rec.last_of_run      = 1'b1;

		tot_rec                   = '0;
		tot_rec.record_kind       = wpt_pkg::RecTotals;
		tot_rec.total_words       = total_q;
		tot_rec.total_paragraphs  = par_q;
		tot_rec.last_of_run       = 1'b1;
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		par_d    = par_q;
		wip_d    = wip_q;
		begin_d  = begin_q;
		total_d  = total_q;
		wip_base = wip_q;
		res      = '0;

		if (item.end_of_text) begin
			// Flush an open word ahead of the totals, then clear for the next text.
			if (phase_q == wpt_pkg::PH_IN_WORD) begin
				res.count             = 2'd2;
				res.rec_a             = word_rec;
				res.rec_a.last_of_run = 1'b0;
				res.rec_b             = tot_rec;
			end else begin
				res.count = 2'd1;
				res.rec_a = tot_rec;
			end
			phase_d = wpt_pkg::PH_PAR_BEGIN;
			pos_d   = '0;
			par_d   = '0;
			wip_d   = '0;
			begin_d = '0;
			total_d = '0;
		end else if (pos_q < wpt_pkg::PosLimit) begin
			case (item.char_code)
				wpt_pkg::CharNewline: begin
					case (phase_q)
						wpt_pkg::PH_IN_WORD: begin
							res.count = 2'd1;
							res.rec_a = word_rec;
							phase_d   = wpt_pkg::PH_LINE_BEGIN;
						end
						wpt_pkg::PH_LINE_BEGIN: phase_d = wpt_pkg::PH_PAR_BEGIN;
						wpt_pkg::PH_BETWEEN:    phase_d = wpt_pkg::PH_LINE_BEGIN;
						default:                phase_d = phase_q;
					endcase
				end
				wpt_pkg::CharSpace, wpt_pkg::CharTab: begin
					if (phase_q == wpt_pkg::PH_IN_WORD) begin
						res.count = 2'd1;
						res.rec_a = word_rec;
						phase_d   = wpt_pkg::PH_BETWEEN;
					end
				end
				default: begin
					if (phase_q != wpt_pkg::PH_IN_WORD) begin
						// A word character outside a word opens one; at paragraph begin
						// it opens a paragraph too.
						if (phase_q == wpt_pkg::PH_PAR_BEGIN) begin
							par_d    = wpt_pkg::sat_inc(par_q);
							wip_base = '0;
						end
						begin_d = pos_q[15:0];
						wip_d   = wpt_pkg::sat_inc(wip_base);
						total_d = wpt_pkg::sat_inc(total_q);
						phase_d = wpt_pkg::PH_IN_WORD;
					end
				end
			endcase
			pos_d = pos_q + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wpt_pkg::PH_PAR_BEGIN;
			pos_q   <= '0;
			par_q   <= '0;
			wip_q   <= '0;
			begin_q <= '0;
			total_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			par_q   <= par_d;
			wip_q   <= wip_d;
			begin_q <= begin_d;
			total_q <= total_d;
		end
	end

	`WPT_NEVER(a_pos_limit, pos_q > wpt_pkg::PosLimit, "char position past limit")
	`WPT_NEVER(a_wip_le_total, wip_q > total_q, "word in paragraph exceeds word total")
	`WPT_ASSERT(a_eot_clears, (advance && item.end_of_text) |=> (total_q == '0 && par_q == '0), "end item did not clear counters")

endmodule

// File: hw/rtl/wpt_rec_fifo.sv
`include "word_paragraph_tokenizer_core_defines.svh"

module wpt_rec_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wpt_pkg::step_res_t    push,
	output logic                  room,
	output logic                  rec_valid,
	input  logic                  rec_stall,
	output wpt_pkg::rec_item_t    rec_data
);

	wpt_pkg::rec_item_t mem_q [wpt_pkg::RecFifoDepth];
	logic [wpt_pkg::RecPtrW-1:0] wr_q, rd_q;
	logic [wpt_pkg::RecCntW-1:0] cnt_q;
	logic pop;

	// Room for a full two-record step regardless of the read side.
	assign room      = cnt_q <= wpt_pkg::RecCntW'(wpt_pkg::RecFifoDepth - 2);
	assign rec_valid = cnt_q != '0;
	assign rec_data  = mem_q[rd_q];
	assign pop       = rec_valid && !rec_stall;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.rec_a;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + wpt_pkg::RecPtrW'(1)] <= push.rec_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + wpt_pkg::RecPtrW'(push.count);
			rd_q  <= rd_q + wpt_pkg::RecPtrW'(pop);
			cnt_q <= cnt_q + wpt_pkg::RecCntW'(push.count) - wpt_pkg::RecCntW'(pop);
		end
	end

	`WPT_NEVER(a_cnt_max, cnt_q > wpt_pkg::RecCntW'(wpt_pkg::RecFifoDepth), "record queue overflow")
	`WPT_ASSERT(a_push_room, (push.count != 2'd0) |-> room, "push without room")
	`WPT_ASSERT(a_cnt_two, (push.count == 2'd2 && !pop) |=> (cnt_q == $past(cnt_q) + wpt_pkg::RecCntW'(2)), "double push miscounted")

endmodule

// File: hw/rtl/word_paragraph_tokenizer_core.sv
// Channel | Direction | Handshake            | Payload
// chr     | in        | chr_valid, chr_stall | chr_data (wpt_pkg::chr_item_t)
// rec     | out       | rec_valid, rec_stall | rec_data (wpt_pkg::rec_item_t)
//
// One character transfer a cycle is taken at full rate while chr_stall is low; each
// character yields zero or one record, the end item one or two.
// A chr transfer reaches rec through the input register and then the record queue.
// The four-entry record queue sets the rate: chr_stall rises only when an item is held
// and fewer than two queue entries are free, so a stalled rec side backs up into chr.
// arst_n clears phase, counters and queue pointers at once; no clearing pass.
`include "word_paragraph_tokenizer_core_defines.svh"

module word_paragraph_tokenizer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  chr_valid,
	output logic                  chr_stall,
	input  wpt_pkg::chr_item_t    chr_data,
	output logic                  rec_valid,
	input  logic                  rec_stall,
	output wpt_pkg::rec_item_t    rec_data
);

	// Input register: one held character item.
	wpt_pkg::chr_item_t chr_s1;
	logic               valid_s1;

	wpt_pkg::step_res_t step_res;
	wpt_pkg::step_res_t push;
	logic               room;
	logic               advance;
	logic               chr_take;

	// Advance the held item into the step logic whenever the queue can take two records.
	assign advance   = valid_s1 && room;
	// Hold the channel only while the held item cannot move on.
	assign chr_stall = valid_s1 && !room;
	assign chr_take  = chr_valid && !chr_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_take) begin
			chr_s1 <= chr_data;
		end
	end

	wpt_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (chr_s1),
		.res     (step_res)
	);

	// Drop the step's records unless the item really advances.
	always_comb begin
		push = step_res;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	wpt_rec_fifo u_rec_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

	`WPT_ASSERT(a_stall_needs_item, chr_stall |-> valid_s1, "stall with empty input register")
	`WPT_ASSERT(a_take_loads, chr_take |=> valid_s1, "transfer not held")
	`WPT_ASSERT(a_eot_last, (advance && chr_s1.end_of_text) |-> (step_res.count != 2'd0), "end item gave no record")

endmodule

// File: tb/word_paragraph_tokenizer_checker.sv
`timescale 1ns / 1ps

module word_paragraph_tokenizer_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chr_valid,
	input  logic               chr_stall,
	input  wpt_pkg::chr_item_t chr_data,
	input  logic               rec_valid,
	input  logic               rec_stall,
	input  wpt_pkg::rec_item_t rec_data,
	output int                 fail_count,
	output int                 records_owed,
	output int                 texts_done,
	output int                 chars_taken,
	output int                 words_seen
);
	import wpt_pkg::*;

	// Tokenizer state as the text so far implies it
	phase_t      ph;
	logic [16:0] pos;
	logic [15:0] par_no;
	logic [15:0] word_no;
	logic [15:0] word_start;
	logic [15:0] word_sum;

	rec_item_t   owed_records[$];

	function automatic logic [15:0] count_up(logic [15:0] v);
		return (v == CountLimit) ? v : v + 16'd1;
	endfunction

	function automatic rec_item_t word_record(logic [16:0] stop, logic last);
		rec_item_t r;
		r = '0;
		r.record_kind     = RecWord;
		r.paragraph_index = par_no;
		r.word_index      = word_no;
		r.begin_pos       = word_start;
		r.end_pos         = stop;
		r.last_of_run     = last;
		return r;
	endfunction

	task automatic clear_text();
		ph         = PH_PAR_BEGIN;
		pos        = '0;
		par_no     = '0;
		word_no    = '0;
		word_start = '0;
		word_sum   = '0;
	endtask

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic field_check(string name, logic [16:0] got, logic [16:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Work out the records that one character or end transfer owes
	task automatic tokenize_item(chr_item_t it);
		rec_item_t tot;
		if (it.end_of_text) begin
			if (ph == PH_IN_WORD)
				owed_records.push_back(word_record(pos, 1'b0));
			tot = '0;
			tot.record_kind      = RecTotals;
			tot.total_words      = word_sum;
			tot.total_paragraphs = par_no;
			tot.last_of_run      = 1'b1;
			owed_records.push_back(tot);
			clear_text();
			texts_done++;
		end else begin
			chars_taken++;
			// past the usable length characters drop with no effect
			if (pos < PosLimit) begin
				case (it.char_code)
					CharNewline: begin
						case (ph)
							PH_IN_WORD: begin
								owed_records.push_back(word_record(pos, 1'b1));
								ph = PH_LINE_BEGIN;
							end
							PH_LINE_BEGIN: ph = PH_PAR_BEGIN;
							PH_BETWEEN:    ph = PH_LINE_BEGIN;
							default: ;
						endcase
					end
					CharSpace, CharTab: begin
						if (ph == PH_IN_WORD) begin
							owed_records.push_back(word_record(pos, 1'b1));
							ph = PH_BETWEEN;
						end
					end
					default: begin
						if (ph == PH_PAR_BEGIN) begin
							par_no  = count_up(par_no);
							word_no = '0;
							ph      = PH_LINE_BEGIN;
						end
						if (ph != PH_IN_WORD) begin
							word_start = pos[15:0];
							word_no    = count_up(word_no);
							word_sum   = count_up(word_sum);
							ph         = PH_IN_WORD;
						end
					end
				endcase
				pos = pos + 17'd1;
			end
		end
	endtask

	task automatic check_record(rec_item_t got);
		rec_item_t want;
		if (owed_records.size() == 0) begin
			report_mismatch($sformatf("record %h arrived with nothing owed", got));
		end else begin
			want = owed_records.pop_front();
			if (got.record_kind == RecWord)
				words_seen++;
			field_check("record_kind", 17'(got.record_kind), 17'(want.record_kind));
			field_check("paragraph_index", 17'(got.paragraph_index),
				17'(want.paragraph_index));
			field_check("word_index", 17'(got.word_index), 17'(want.word_index));
			field_check("begin_pos", 17'(got.begin_pos), 17'(want.begin_pos));
			field_check("end_pos", got.end_pos, want.end_pos);
			field_check("total_words", 17'(got.total_words), 17'(want.total_words));
			field_check("total_paragraphs", 17'(got.total_paragraphs),
				17'(want.total_paragraphs));
			field_check("last_of_run", 17'(got.last_of_run), 17'(want.last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_text();
			owed_records.delete();
			fail_count   = 0;
			records_owed = 0;
			texts_done   = 0;
			chars_taken  = 0;
			words_seen   = 0;
		end else begin
			if (rec_valid && !rec_stall)
				check_record(rec_data);
			if (chr_valid && !chr_stall)
				tokenize_item(chr_data);
			records_owed = owed_records.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import wpt_pkg::*;

	// Cycles with no transfer on either channel before the run is called hung
	localparam int IdleLimit   = 2000;
	// Random items to send after the directed texts
	localparam int RandomItems = 925;

	logic      clk;
	logic      arst_n;
	logic      chr_valid;
	logic      chr_stall;
	chr_item_t chr_data;
	logic      rec_valid;
	logic      rec_stall;
	rec_item_t rec_data;

	// High while both sides run without gaps or stalls
	logic      quiet;

	int fail_count;
	int records_owed;
	int texts_done;
	int chars_taken;
	int words_seen;
	int idle_cycles = 0;

	word_paragraph_tokenizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_data  (chr_data),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

	word_paragraph_tokenizer_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.chr_valid    (chr_valid),
		.chr_stall    (chr_stall),
		.chr_data     (chr_data),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.rec_data     (rec_data),
		.fail_count   (fail_count),
		.records_owed (records_owed),
		.texts_done   (texts_done),
		.chars_taken  (chars_taken),
		.words_seen   (words_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// End the run if neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (chr_valid && !chr_stall) || (rec_valid && !rec_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IdleLimit) begin
			$display("[word_paragraph_tokenizer_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Record side: hold stall for a random number of cycles before each transfer,
	// then keep it low until the record is taken.
	initial begin
		int hold;
		rec_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 10);
			repeat (hold) begin
				@(negedge clk);
				rec_stall <= 1'b1;
			end
			@(negedge clk);
			rec_stall <= 1'b0;
			do @(posedge clk); while (!(rec_valid && !rec_stall));
		end
	end

	// Drive one character or end item; return right after its transfer edge.
	// Valid drops only during a gap, so back-to-back items keep it high.
	task automatic send_item(input logic eot, input logic [15:0] code);
		int        gap;
		chr_item_t it;
		it.char_code   = code;
		it.end_of_text = eot;
		gap = quiet ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			chr_valid <= 1'b0;
		end
		@(negedge clk);
		chr_valid <= 1'b1;
		chr_data  <= it;
		do @(posedge clk); while (chr_stall);
	endtask

	// Stop sending and hold off until every owed record has come out
	task automatic drain_records();
		@(negedge clk);
		chr_valid <= 1'b0;
		wait (records_owed == 0);
	endtask

	// Any code except the three separators; the extremes now and then
	function automatic logic [15:0] pick_word_char();
		logic [15:0] c;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		do c = 16'($urandom); while (c == CharTab || c == CharNewline || c == CharSpace);
		return c;
	endfunction

	// Mostly word characters, with enough newlines to make empty lines common
	function automatic logic [15:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return pick_word_char();
		else if (r < 70)
			return CharSpace;
		else if (r < 78)
			return CharTab;
		else
			return CharNewline;
	endfunction

	initial begin
		int sent;
		int len;

		arst_n    = 1'b0;
		chr_valid = 1'b0;
		chr_data  = '0;
		quiet     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Empty text: totals only, both zero
		send_item(1'b1, 16'hFFFF);

		// Separators at paragraph start, extreme codes, codes next to the
		// separators, an empty line, and an end that closes an open word
		send_item(1'b0, CharSpace);
		send_item(1'b0, CharTab);
		send_item(1'b0, CharNewline);
		send_item(1'b0, 16'hFFFF);
		send_item(1'b0, 16'h0000);
		send_item(1'b0, CharSpace);
		send_item(1'b0, 16'h0021);
		send_item(1'b0, CharTab);
		send_item(1'b0, 16'h000B);
		send_item(1'b0, CharNewline);
		send_item(1'b0, 16'h0008);
		send_item(1'b0, CharNewline);
		send_item(1'b0, CharNewline);
		send_item(1'b0, 16'h0041);
		send_item(1'b0, CharSpace);
		send_item(1'b0, CharNewline);
		send_item(1'b0, 16'h001F);
		send_item(1'b1, 16'h0000);

		// End item between words: no flush, totals only
		send_item(1'b0, 16'h8000);
		send_item(1'b0, CharSpace);
		send_item(1'b1, 16'h5555);
		drain_records();

		// Random texts of varied length; some run gap-free, some wait for drain
		sent = 0;
		while (sent < RandomItems) begin
			quiet = ($urandom_range(0, 4) == 0);
			len   = $urandom_range(0, 40);
			for (int i = 0; i < len; i++)
				send_item(1'b0, pick_char());
			send_item(1'b1, 16'($urandom));
			sent += len + 1;
			if ($urandom_range(0, 7) == 0)
				drain_records();
		end
		quiet = 1'b0;

		// Let the last records out, then watch a little longer for strays
		drain_records();
		repeat (10) @(posedge clk);

		$display("Covered %0d texts, %0d characters and %0d word records.",
			texts_done, chars_taken, words_seen);
		$display("Texts ran from empty to forty characters, with gaps, stalls and bursts.");
		if (fail_count == 0)
			$display("[word_paragraph_tokenizer_core] OK");
		else
			$display("[word_paragraph_tokenizer_core] ERROR");
		$finish;
	end

endmodule
